// ===== sv/abl_pkg.sv =====
// shared types, constants and hash for the address balance ledger
package abl_pkg;

	localparam int TABLE_ENTRIES = 4096;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int KEY_W         = 160;
	localparam int AMT_W         = 52;
	localparam int BAL_W         = 64;
	localparam int CNT_W         = 32;
	localparam int TIME_W        = 32;
	localparam int IN_W          = 248;
	localparam int OUT_W         = 192;
	localparam int USER_W        = 2;

	typedef logic [IDX_W-1:0] idx_t;

	// one table entry as stored in the record memory
	typedef struct packed {
		logic              valid;
		logic [KEY_W-1:0]  key;
		logic [BAL_W-1:0]  balance;
		logic [CNT_W-1:0]  in_count;
		logic [CNT_W-1:0]  out_count;
		logic [TIME_W-1:0] in_time;
		logic [TIME_W-1:0] out_time;
	} entry_t;

	// home slot: fold the key into IDX_W bits, then bring it below the table size
	function automatic idx_t home_slot(input logic [KEY_W-1:0] key);
		logic [IDX_W-1:0] h;
		logic [IDX_W:0]   r;
		h = '0;
		for (int i = 0; i < KEY_W; i++) begin
			h[i % IDX_W] = h[i % IDX_W] ^ key[i];
		end
		r = {1'b0, h};
		if (r >= (IDX_W + 1)'(TABLE_ENTRIES)) begin
			r = r - (IDX_W + 1)'(TABLE_ENTRIES);
		end
		return r[IDX_W-1:0];
	endfunction

endpackage

// ===== sv/address_balance_ledger.sv =====
// address balance ledger top level: hashed account table with linear probing
// One item at a time. After reset the block sweeps the record memory to clear
// every entry before the first item is taken. Each probe step of an item is a
// registered read of the single-port record memory followed by a compare; a
// probe past an occupied slot with another key repeats the step at the next
// slot. The final compare writes the updated entry back, unless the table is
// full, and loads the result register, waiting until the output register is
// free. A result may wait in the output register while the next item is accepted.
module address_balance_ledger (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// key_high[31:0], key_mid[95:32], key_low[159:96], amount[211:160],
	// block_time[243:212], zero fill up to 247
	input  logic [abl_pkg::IN_W-1:0]    s_tdata,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// balance[63:0], inbound_count[95:64], outbound_count[127:96],
	// last_in_time[159:128], last_out_time[191:160]
	output logic [abl_pkg::OUT_W-1:0]   m_tdata,
	// new_entry[0], table_full[1]
	output logic [abl_pkg::USER_W-1:0]  m_tuser
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CHECK
	} state_t;

	state_t                       state_q;
	abl_pkg::idx_t                slot_q;
	abl_pkg::idx_t                probe_q;
	logic [abl_pkg::KEY_W-1:0]    key_q;
	logic [abl_pkg::AMT_W-1:0]    amt_q;
	logic [abl_pkg::TIME_W-1:0]   time_q;
	logic                         m_tvalid_q;
	logic [abl_pkg::OUT_W-1:0]    m_tdata_q;
	logic [abl_pkg::USER_W-1:0]   m_tuser_q;

	abl_pkg::entry_t              mem [abl_pkg::TABLE_ENTRIES];
	abl_pkg::entry_t              rd_data_q;

	logic                         s_fire;
	logic                         out_free;
	logic                         hit;
	logic                         last_probe;
	logic                         credit;
	logic                         result_load;
	abl_pkg::entry_t              base;
	abl_pkg::entry_t              upd;
	abl_pkg::entry_t              wr_data;
	logic                         wr_en;
	abl_pkg::idx_t                next_slot;

	assign s_tready = (state_q == ST_IDLE);
	assign s_fire   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	// probe compare and entry update
	assign hit        = rd_data_q.valid && (rd_data_q.key == key_q);
	assign last_probe = (probe_q == abl_pkg::IDX_W'(abl_pkg::TABLE_ENTRIES - 1));
	assign credit     = !amt_q[abl_pkg::AMT_W-1] && (amt_q != '0);
	assign next_slot  = (slot_q == abl_pkg::IDX_W'(abl_pkg::TABLE_ENTRIES - 1)) ?
		'0 : slot_q + abl_pkg::IDX_W'(1);
	assign result_load = (state_q == ST_CHECK) && out_free &&
		!(rd_data_q.valid && !hit && !last_probe);

	always_comb begin
		base       = hit ? rd_data_q : '0;
		upd        = base;
		upd.valid  = 1'b1;
		upd.key    = key_q;
		if (credit) begin
			upd.in_time = time_q;
			if (base.in_count != '1) begin
				upd.in_count = base.in_count + abl_pkg::CNT_W'(1);
			end
		end else begin
			upd.out_time = time_q;
			if (base.out_count != '1) begin
				upd.out_count = base.out_count + abl_pkg::CNT_W'(1);
			end
		end
		upd.balance = base.balance +
			{{(abl_pkg::BAL_W - abl_pkg::AMT_W){amt_q[abl_pkg::AMT_W-1]}}, amt_q};
	end

	// memory write selection: clearing sweep or entry write-back
	always_comb begin
		wr_en   = 1'b0;
		wr_data = upd;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_data = '0;
			end
			ST_CHECK: begin
				wr_en = out_free && (hit || !rd_data_q.valid);
			end
			default: begin
				wr_en = 1'b0;
			end
		endcase
	end

	// record memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[slot_q] <= wr_data;
		end
		rd_data_q <= mem[slot_q];
	end

	// input item registers
	always_ff @(posedge clk) begin
		if (s_fire) begin
			key_q  <= {s_tdata[159:96], s_tdata[95:32], s_tdata[31:0]};
			amt_q  <= s_tdata[211:160];
			time_q <= s_tdata[243:212];
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			slot_q     <= '0;
			probe_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (result_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					slot_q <= next_slot;
					if (slot_q == abl_pkg::IDX_W'(abl_pkg::TABLE_ENTRIES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_fire) begin
						slot_q  <= abl_pkg::home_slot(s_tdata[159:0]);
						probe_q <= '0;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (rd_data_q.valid && !hit && !last_probe) begin
						slot_q  <= next_slot;
						probe_q <= probe_q + abl_pkg::IDX_W'(1);
						state_q <= ST_READ;
					end else if (out_free) begin
						if (rd_data_q.valid && !hit) begin
							m_tdata_q <= '0;
							m_tuser_q <= 2'b10;
						end else begin
							m_tdata_q <= {upd.out_time, upd.in_time, upd.out_count,
								upd.in_count, upd.balance};
							m_tuser_q <= {1'b0, !hit};
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== tb/address_balance_ledger_tb.sv =====
// self-checking testbench for the address balance ledger top level
`timescale 1ns / 1ps

module address_balance_ledger_tb;

	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam int RANDOM_ITEMS = 1200;
	localparam int KEY_POOL     = 64;

	// one input transaction
	typedef struct {
		logic [31:0] key_high;
		logic [63:0] key_mid;
		logic [63:0] key_low;
		logic [51:0] amount;
		logic [31:0] block_time;
	} movement_t;

	// one result transaction
	typedef struct {
		logic [63:0] balance;
		logic [31:0] in_count;
		logic [31:0] out_count;
		logic [31:0] in_time;
		logic [31:0] out_time;
		logic        new_entry;
		logic        table_full;
	} account_t;

	// key width fields in the predictor are kept separately
	typedef struct {
		logic [159:0] key;
		account_t     rec;
	} ledger_row_t;

	logic                         clk;
	logic                         arst_n;
	logic                         s_tvalid;
	logic                         s_tready;
	logic [abl_pkg::IN_W-1:0]     s_tdata;
	logic                         m_tvalid;
	logic                         m_tready;
	logic [abl_pkg::OUT_W-1:0]    m_tdata;
	logic [abl_pkg::USER_W-1:0]   m_tuser;

	movement_t   pending_moves[$];
	account_t    expected_records[$];
	ledger_row_t ledger[logic [159:0]];
	int          accounts_open;
	int          errors;
	int          cycles;
	int          hold_off;
	int          send_wait;
	int          recv_wait;
	bit          drain_pause;
	bit          in_taken;
	bit          out_taken;
	logic [159:0] key_pool[KEY_POOL];

	address_balance_ledger u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// ledger update for one accepted movement
	function automatic account_t post_movement(movement_t mv);
		logic [159:0] k;
		account_t     r;
		logic         credit;
		k = {mv.key_low, mv.key_mid, mv.key_high};
		credit = !mv.amount[51] && (mv.amount != '0);
		if (!ledger.exists(k)) begin
			if (accounts_open >= abl_pkg::TABLE_ENTRIES) begin
				r = '{default: '0};
				r.table_full = 1'b1;
				return r;
			end
			ledger[k].key = k;
			ledger[k].rec = '{default: '0};
			accounts_open++;
			r.new_entry = 1'b1;
		end else begin
			r.new_entry = 1'b0;
		end
		r.balance   = ledger[k].rec.balance + {{12{mv.amount[51]}}, mv.amount};
		r.in_count  = ledger[k].rec.in_count;
		r.out_count = ledger[k].rec.out_count;
		r.in_time   = ledger[k].rec.in_time;
		r.out_time  = ledger[k].rec.out_time;
		if (credit) begin
			r.in_time = mv.block_time;
			if (r.in_count != '1) r.in_count++;
		end else begin
			r.out_time = mv.block_time;
			if (r.out_count != '1) r.out_count++;
		end
		r.table_full = 1'b0;
		ledger[k].rec = r;
		return r;
	endfunction

	function automatic logic [51:0] rand_amount();
		case ($urandom_range(0, 5))
			0: return 52'($urandom_range(1, 100000));
			1: return -52'($urandom_range(1, 100000));
			2: return '0;
			3: return 52'({$urandom, $urandom});
			4: return $urandom_range(0, 1) ? 52'h7FFFFFFFFFFFF : 52'h8000000000000;
			default: return 52'($urandom_range(0, 2)) - 52'd1;
		endcase
	endfunction

	function automatic movement_t make_move(logic [159:0] k, logic [51:0] a, logic [31:0] t);
		movement_t mv;
		mv.key_high   = k[31:0];
		mv.key_mid    = k[95:32];
		mv.key_low    = k[159:96];
		mv.amount     = a;
		mv.block_time = t;
		return mv;
	endfunction

	function automatic logic [159:0] rand_key();
		return {$urandom, $urandom, $urandom, $urandom, $urandom};
	endfunction

	// append one movement to the driver queue
	function automatic void queue_move(movement_t mv);
		pending_moves = {pending_moves, mv};
	endfunction

	// handshakes seen at the rising edge
	always @(posedge clk) begin
		in_taken  <= arst_n && s_tvalid && s_tready;
		out_taken <= arst_n && m_tvalid && m_tready;
	end

	// driver: offers queued movements, updates the ledger on acceptance
	always @(negedge clk) begin
		int        w;
		movement_t mv_done;
		w = send_wait;
		if (in_taken) begin
			mv_done = pending_moves.pop_front();
			expected_records = {expected_records, post_movement(mv_done)};
			w = $urandom_range(0, 3);
		end
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !in_taken) begin
			s_tvalid <= 1'b1;
		end else if (drain_pause) begin
			s_tvalid <= 1'b0;
		end else if (w > 0) begin
			w = w - 1;
			s_tvalid <= 1'b0;
		end else if (pending_moves.size() != 0) begin
			s_tvalid <= 1'b1;
			s_tdata  <= {4'b0, pending_moves[0].block_time, pending_moves[0].amount,
				pending_moves[0].key_low, pending_moves[0].key_mid,
				pending_moves[0].key_high};
		end else begin
			s_tvalid <= 1'b0;
		end
		send_wait <= w;
	end

	// receiver readiness, including the long hold-off
	always @(negedge clk) begin
		int w;
		w = recv_wait;
		if (out_taken) w = $urandom_range(0, 3);
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else if (w > 0) begin
			w = w - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
		recv_wait <= w;
	end

	// monitor: compare each result with the oldest expected record
	always @(posedge clk) begin
		account_t want;
		cycles <= cycles + 1;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_records.size() == 0) begin
				$error("unexpected result transaction");
				errors++;
			end else begin
				want = expected_records.pop_front();
				if (m_tdata[63:0] !== want.balance) begin
					$error("balance exp %h got %h", want.balance, m_tdata[63:0]);
					errors++;
				end
				if (m_tdata[95:64] !== want.in_count) begin
					$error("inbound_count exp %h got %h", want.in_count, m_tdata[95:64]);
					errors++;
				end
				if (m_tdata[127:96] !== want.out_count) begin
					$error("outbound_count exp %h got %h", want.out_count,
						m_tdata[127:96]);
					errors++;
				end
				if (m_tdata[159:128] !== want.in_time) begin
					$error("last_in_time exp %h got %h", want.in_time, m_tdata[159:128]);
					errors++;
				end
				if (m_tdata[191:160] !== want.out_time) begin
					$error("last_out_time exp %h got %h", want.out_time,
						m_tdata[191:160]);
					errors++;
				end
				if (m_tuser[0] !== want.new_entry) begin
					$error("new_entry exp %b got %b", want.new_entry, m_tuser[0]);
					errors++;
				end
				if (m_tuser[1] !== want.table_full) begin
					$error("table_full exp %b got %b", want.table_full, m_tuser[1]);
					errors++;
				end
			end
		end
	end

	// cycle limit
	always @(posedge clk) begin
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic wait_drained();
		while (pending_moves.size() != 0 || expected_records.size() != 0 || s_tvalid)
			@(posedge clk);
	endtask

	initial begin
		logic [159:0] k;
		int           n;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		errors = 0;
		cycles = 0;
		hold_off = 0;
		send_wait = 0;
		recv_wait = 0;
		drain_pause = 1'b0;
		accounts_open = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: field extremes, credit, zero and debit, wrap
		queue_move(make_move('0, 52'd1, 32'd0));
		queue_move(make_move('0, 52'd0, 32'hFFFFFFFF));
		queue_move(make_move('0, 52'h8000000000000, 32'h1));
		queue_move(make_move('1, 52'h7FFFFFFFFFFFF, 32'hFFFFFFFF));
		queue_move(make_move('1, 52'hFFFFFFFFFFFFF, 32'h0));
		queue_move(make_move({32'h0, 64'h0, 64'h1}, 52'h7FFFFFFFFFFFF, 32'h5));
		for (int i = 0; i < 4; i++)
			queue_move(make_move({32'h0, 64'h0, 64'h1}, 52'h7FFFFFFFFFFFF, $urandom));
		queue_move(make_move({160'h1} << 159, 52'h123456789ABCD, 32'h55AA));
		queue_move(make_move({160'h1} << 159, -52'd1, 32'hAA55));
		for (int i = 0; i < 6; i++)
			queue_move(make_move(rand_key(), rand_amount(), $urandom));

		// random movements over a reused key pool, with fresh keys mixed in
		for (int i = 0; i < KEY_POOL; i++) key_pool[i] = rand_key();
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			k = $urandom_range(0, 3) ? key_pool[$urandom_range(0, KEY_POOL - 1)]
				: rand_key();
			queue_move(make_move(k, rand_amount(), $urandom));
			if (n == 300) begin
				// long receiver hold-off while the sender keeps offering
				wait (pending_moves.size() < 40);
				hold_off = 400;
			end
			if (n == 700) begin
				// sender pauses until every result is back
				wait (pending_moves.size() == 0);
				@(posedge clk);
				drain_pause = 1'b1;
				wait (expected_records.size() == 0 && !s_tvalid);
				@(negedge clk);
				drain_pause = 1'b0;
			end
		end

		for (int i = 0; i < 30; i++) begin
			k = $urandom_range(0, 1) ? rand_key() : key_pool[$urandom_range(0, KEY_POOL - 1)];
			queue_move(make_move(k, rand_amount(), $urandom));
		end

		wait_drained();
		repeat (100) @(posedge clk);
		if (errors == 0 && expected_records.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== address_balance_ledger.f =====
sv/abl_pkg.sv
sv/address_balance_ledger.sv
tb/address_balance_ledger_tb.sv
